// File: design/jsrt_pkg.sv
// Shared types and constants for the job slot ring tracker.
package jsrt_pkg;

  localparam int unsigned IdxW   = 4;
  localparam int unsigned CountW = 5;
  localparam int unsigned StatW  = 3;
  localparam int unsigned CmdW   = 2;

  localparam logic [CountW-1:0] SlotCountReset = 5'd16;

  typedef enum logic [CmdW-1:0] {
    CMD_ACQUIRE = 2'd0,
    CMD_SUBMIT  = 2'd1,
    CMD_FINISH  = 2'd2,
    CMD_RELEASE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    SLOT_FREE     = 2'd0,
    SLOT_RESERVED = 2'd1,
    SLOT_QUEUED   = 2'd2,
    SLOT_FINISHED = 2'd3
  } slot_e;

  typedef enum logic [StatW-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_SIZE  = 3'd1,
    ST_FULL      = 3'd2,
    ST_CORRUPT   = 3'd3,
    ST_BAD_ID    = 3'd4,
    ST_BAD_STATE = 3'd5,
    ST_ORDER     = 3'd6
  } status_e;

  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] addr;
    slot_e           data;
  } slot_wr_t;

endpackage

// File: design/jsrt_slot_file.sv
// Slot state register file with one read port and one write port, cleared at reset.
module jsrt_slot_file #(
  parameter int unsigned Depth = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [jsrt_pkg::IdxW-1:0] rd_addr_i,
  output jsrt_pkg::slot_e         rd_state_o,
  input  jsrt_pkg::slot_wr_t      wr_i
);
  import jsrt_pkg::*;

  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  slot_e state_q [Depth];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        state_q[i] <= SLOT_FREE;
      end
    end else if (wr_i.en && (32'(wr_i.addr) < Depth)) begin
      state_q[wr_i.addr[Aw-1:0]] <= wr_i.data;
    end
  end

  assign rd_state_o = (32'(rd_addr_i) < Depth) ? state_q[rd_addr_i[Aw-1:0]] : SLOT_FREE;

endmodule

// File: design/jsrt_ctrl.sv
// Command decision logic with the ring indices and the held count.
module jsrt_ctrl #(
  parameter int unsigned MaxSlots = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  jsrt_pkg::cmd_e              cmd_i,
  input  logic [jsrt_pkg::IdxW-1:0]   slot_id_i,
  input  logic [jsrt_pkg::CountW-1:0] slot_count_i,
  input  jsrt_pkg::slot_e             rd_state_i,
  output logic [jsrt_pkg::IdxW-1:0]   rd_addr_o,
  output jsrt_pkg::slot_wr_t          wr_o,
  output jsrt_pkg::status_e           status_o,
  output logic [jsrt_pkg::IdxW-1:0]   granted_o,
  output logic [jsrt_pkg::CountW-1:0] occupancy_o
);
  import jsrt_pkg::*;

  logic [IdxW-1:0]   write_index_q, write_index_d;
  logic [IdxW-1:0]   read_index_q, read_index_d;
  logic [CountW-1:0] held_count_q, held_count_d;
  logic [CountW-1:0] count_mask;
  logic              size_bad;
  logic              id_ok;
  logic              ok;
  slot_e             from_state;
  slot_e             to_state;

  assign rd_addr_o  = (cmd_i == CMD_ACQUIRE) ? write_index_q : slot_id_i;
  assign count_mask = slot_count_i - 5'd1;
  assign size_bad   = ((slot_count_i & count_mask) != '0) || (32'(slot_count_i) > MaxSlots);
  assign id_ok      = ({1'b0, slot_id_i} < slot_count_i) && (32'(slot_id_i) < MaxSlots);

  always_comb begin
    status_o      = ST_OK;
    granted_o     = '0;
    write_index_d = write_index_q;
    read_index_d  = read_index_q;
    held_count_d  = held_count_q;
    from_state    = SLOT_RESERVED;
    to_state      = SLOT_QUEUED;
    case (cmd_i)
      CMD_ACQUIRE: begin
        to_state = SLOT_RESERVED;
        if (size_bad) begin
          status_o = ST_BAD_SIZE;
        end else if (held_count_q >= slot_count_i) begin
          status_o = ST_FULL;
        end else if ((32'(write_index_q) >= MaxSlots) || (rd_state_i != SLOT_FREE)) begin
          status_o = ST_CORRUPT;
        end else begin
          granted_o     = write_index_q;
          write_index_d = (write_index_q + 4'd1) & count_mask[IdxW-1:0];
          held_count_d  = held_count_q + 5'd1;
        end
      end
      CMD_SUBMIT, CMD_FINISH: begin
        if (cmd_i == CMD_FINISH) begin
          from_state = SLOT_QUEUED;
          to_state   = SLOT_FINISHED;
        end
        if (!id_ok) begin
          status_o = ST_BAD_ID;
        end else if (rd_state_i != from_state) begin
          status_o = ST_BAD_STATE;
        end
      end
      CMD_RELEASE: begin
        to_state = SLOT_FREE;
        if (!id_ok) begin
          status_o = ST_BAD_ID;
        end else if (slot_id_i != read_index_q) begin
          status_o = ST_ORDER;
        end else if (rd_state_i != SLOT_FINISHED) begin
          status_o = ST_BAD_STATE;
        end else begin
          read_index_d = (read_index_q + 4'd1) & count_mask[IdxW-1:0];
          if (held_count_q != '0) begin
            held_count_d = held_count_q - 5'd1;
          end
        end
      end
      default: begin
        status_o = ST_BAD_ID;
      end
    endcase
  end

  assign ok          = (status_o == ST_OK);
  assign occupancy_o = held_count_d;
  assign wr_o.en     = en_i && ok;
  assign wr_o.addr   = rd_addr_o;
  assign wr_o.data   = to_state;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      write_index_q <= '0;
      read_index_q  <= '0;
      held_count_q  <= '0;
    end else if (en_i) begin
      write_index_q <= write_index_d;
      read_index_q  <= read_index_d;
      held_count_q  <= held_count_d;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) held_count_q <= 5'd16)
    else $error("Held count exceeds the largest ring.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && !ok |=> $stable(held_count_q) && $stable(write_index_q) && $stable(read_index_q))
    else $error("A failed command changed the ring state.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && ok && (cmd_i == CMD_ACQUIRE) |=> held_count_q == $past(held_count_q) + 5'd1)
    else $error("A successful acquire did not add one held slot.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && ok && (cmd_i != CMD_ACQUIRE) && (cmd_i != CMD_RELEASE) |=> $stable(held_count_q))
    else $error("Submit or finish changed the held count.");
`endif

endmodule

// File: design/job_slot_ring_tracker_top.sv
// Top level of the job slot ring tracker: input register, command logic and result register.
// The block takes one command transaction per clock cycle when the output side is ready and
// returns one result transaction for each; a command passes through the input register and then
// the result register. The rate is set by the single read and write of the slot state file
// per cycle, which each command needs once. The slot count register is written through
// cfg_we_i and takes effect for the next command that leaves the input register.
module job_slot_ring_tracker_top #(
  parameter int unsigned MAX_SLOTS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [jsrt_pkg::CountW-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [jsrt_pkg::CmdW-1:0]   cmd_i,
  input  logic [jsrt_pkg::IdxW-1:0]   slot_id_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [jsrt_pkg::StatW-1:0]  status_o,
  output logic [jsrt_pkg::IdxW-1:0]   granted_slot_o,
  output logic [jsrt_pkg::CountW-1:0] occupancy_o
);
  import jsrt_pkg::*;

  localparam int unsigned StoreDepth = (MAX_SLOTS < (2 ** IdxW)) ? MAX_SLOTS : (2 ** IdxW);

  logic              in_vld_q;
  cmd_e              cmd_q;
  logic [IdxW-1:0]   slot_id_q;
  logic [CountW-1:0] slot_count_q;
  logic              out_vld_q;
  status_e           status_q;
  logic [IdxW-1:0]   granted_q;
  logic [CountW-1:0] occupancy_q;
  logic              advance;

  logic [IdxW-1:0]   rd_addr;
  slot_e             rd_state;
  slot_wr_t          slot_wr;
  status_e           status_d;
  logic [IdxW-1:0]   granted_d;
  logic [CountW-1:0] occupancy_d;

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= SlotCountReset;
    end else if (cfg_we_i) begin
      slot_count_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      cmd_q     <= cmd_e'(cmd_i);
      slot_id_q <= slot_id_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      status_q    <= status_d;
      granted_q   <= granted_d;
      occupancy_q <= occupancy_d;
    end
  end

  jsrt_slot_file #(
    .Depth(StoreDepth)
  ) u_slot_file (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (rd_addr),
    .rd_state_o(rd_state),
    .wr_i      (slot_wr)
  );

  jsrt_ctrl #(
    .MaxSlots(MAX_SLOTS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (advance),
    .cmd_i       (cmd_q),
    .slot_id_i   (slot_id_q),
    .slot_count_i(slot_count_q),
    .rd_state_i  (rd_state),
    .rd_addr_o   (rd_addr),
    .wr_o        (slot_wr),
    .status_o    (status_d),
    .granted_o   (granted_d),
    .occupancy_o (occupancy_d)
  );

  assign out_valid_o    = out_vld_q;
  assign status_o       = status_q;
  assign granted_slot_o = granted_q;
  assign occupancy_o    = occupancy_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (granted_q != '0) |-> status_q == ST_OK)
    else $error("A slot was granted with an error status.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> occupancy_q <= 5'd16)
    else $error("Reported occupancy exceeds the largest ring.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_vld_q)
    else $error("A processed transaction did not reach the result register.");
`endif

endmodule
